/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* src/shb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shb_pkg
// Types and constants for the string hash bucket histogram block.
// ----------------------------------------------------------------------------
package shb_pkg;

    // hash kinds
    localparam logic [1:0]  KIND_DJB2 = 2'd0;
    localparam logic [1:0]  KIND_SDBM = 2'd1;
    localparam logic [31:0] DJB2_SEED = 32'd5381;

    // register indexes (word address bit 2)
    localparam logic REG_HASH_KIND    = 1'b0;
    localparam logic REG_BUCKET_COUNT = 1'b1;

    // request and result codes
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_READ = 1'b1;
    localparam logic RES_HASH = 1'b0;
    localparam logic RES_HIT  = 1'b1;

    // restoring division: one quotient bit per cycle
    localparam int  DIV_STEPS = 32;
    localparam int  CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FOLD1,
        S_FOLD2,
        S_FOLD3,
        S_FINISH,
        S_DIV,
        S_MREAD,
        S_INC_LO,
        S_INC_HI,
        S_RDWAIT,
        S_DONE
    } t_state;

    // shared adder control
    typedef struct packed {
        logic sub;
        logic cin;
    } t_alu_op;

    // counter memory control
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage
`default_nettype wire

/* src/shb_alu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shb_alu
// Shared 32-bit adder/subtractor with carry in and carry out.
// ----------------------------------------------------------------------------
module shb_alu
    import shb_pkg::*;
(
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    input  wire t_alu_op     i_op,
    output logic      [31:0] o_sum,
    output logic             o_cout
);

    logic [31:0] w_b;
    logic [32:0] w_full;

    // subtract as a + ~b + 1; carry out high means no borrow
    assign w_b    = i_op.sub ? ~i_b : i_b;
    assign w_full = {1'b0, i_a} + {1'b0, w_b} + {32'd0, i_op.cin};
    assign o_sum  = w_full[31:0];
    assign o_cout = w_full[32];

endmodule
`default_nettype wire

/* src/shb_hit_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shb_hit_mem
// Bucket hit counter store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module shb_hit_mem
    import shb_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire t_mem_ctl      i_ctl,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [63:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [63:0]   o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* src/string_hash_bucket_histogram_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// string_hash_bucket_histogram_top
// djb2 / sdbm string hash with modulo bucket reduction and hit counters.
// ----------------------------------------------------------------------------
//  channel  signals                        direction  payload
//  in       i_in_valid / o_in_ready        in         req_type, byte, flags, index
//  out      o_out_valid / i_out_ready      out        result_kind, hash, hit count
//  cfg      psel penable pwrite paddr ...  in/out     hash_kind @0, bucket_count @4
//
//  Key byte: FOLD1-FOLD2 (djb2) or FOLD1-FOLD3 (sdbm) on the shared 32-bit adder.
//  Last byte with buckets set: then finish, 32 divide steps (one remainder
//  bit per cycle), counter read, low and high increment halves, output load.
//  Counter read request: waits in RDWAIT (memory read port is registered).
//  After reset a clearing pass writes zero to all NUM_BUCKETS counters, one
//  per cycle; requests are held off until the pass is done.
//  A finished result waits in the output register; a new request is taken
//  while it waits, and only the next result load stalls on it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module string_hash_bucket_histogram_top
    import shb_pkg::*;
#(
    parameter int NUM_BUCKETS = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_last_byte,
    input  wire logic [9:0]  i_bucket_index,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_result_kind,
    output logic [31:0]      o_hash_value,
    output logic [63:0]      o_hit_count,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    t_state         r_state, n_state;
    logic [1:0]     r_hash_kind;
    logic [10:0]    r_bucket_count;
    logic [31:0]    r_hash;
    logic [31:0]    r_acc;
    logic [31:0]    r_div;
    logic [10:0]    r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic           r_carry;
    logic [7:0]     r_byte;
    logic           r_last;
    logic           r_rd_ok;
    logic [AW-1:0]  r_clr;
    logic [31:0]    r_res_hash;
    logic           r_res_kind;
    logic           r_out_valid;
    logic           r_out_kind;
    logic [31:0]    r_out_hash;
    logic [63:0]    r_out_hit;

    logic           w_accept;
    logic           w_cfg_wr;
    logic           w_kind_ok;
    logic [10:0]    w_mod;
    logic [31:0]    w_seed;
    logic [11:0]    w_trial;
    logic           w_load_out;
    logic           w_out_free;

    t_alu_op        w_op;
    logic [31:0]    w_a, w_b, w_sum;
    logic           w_cout;

    t_mem_ctl       w_mem;
    logic [AW-1:0]  w_waddr, w_raddr;
    logic [63:0]    w_wdata, w_rdata;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign prdata   = (paddr[2] == REG_BUCKET_COUNT) ? {21'd0, r_bucket_count}
                                                     : {30'd0, r_hash_kind};

    // ------------------------------------------------------------------
    // derived values
    // ------------------------------------------------------------------
    assign w_kind_ok = (r_hash_kind == KIND_DJB2) || (r_hash_kind == KIND_SDBM);
    assign w_seed    = (r_hash_kind == KIND_DJB2) ? DJB2_SEED : 32'd0;
    // modulus saturates at the number of buckets
    assign w_mod     = ({21'd0, r_bucket_count} > 32'(NUM_BUCKETS)) ? 11'(NUM_BUCKETS)
                                                                     : r_bucket_count;
    assign w_trial   = {r_rem, r_div[31]};
    assign w_accept  = i_in_valid & o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_load_out = (r_state == S_DONE) && w_out_free;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(NUM_BUCKETS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_READ) n_state = S_RDWAIT;
                    else if (i_byte_valid && w_kind_ok) n_state = S_FOLD1;
                    else if (i_last_byte) n_state = S_FINISH;
                end
            end
            S_FOLD1: n_state = S_FOLD2;
            S_FOLD2: begin
                if (r_hash_kind == KIND_SDBM) n_state = S_FOLD3;
                else if (r_last) n_state = S_FINISH;
                else n_state = S_IDLE;
            end
            S_FOLD3: n_state = r_last ? S_FINISH : S_IDLE;
            S_FINISH: begin
                if (w_kind_ok && (w_mod != 11'd0)) n_state = S_DIV;
                else n_state = S_DONE;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_MREAD;
            end
            S_MREAD:  n_state = S_INC_LO;
            S_INC_LO: n_state = S_INC_HI;
            S_INC_HI: n_state = S_DONE;
            S_RDWAIT: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // shared adder operands and memory control
    // ------------------------------------------------------------------
    always_comb begin
        w_op    = '{sub: 1'b0, cin: 1'b0};
        w_a     = r_acc;
        w_b     = 32'd0;
        w_mem   = '{we: 1'b0, re: 1'b0};
        w_waddr = AW'(r_rem);
        w_raddr = AW'(r_rem);
        w_wdata = {w_sum, r_acc};
        case (r_state)
            S_CLEAR: begin
                w_mem.we = 1'b1;
                w_waddr  = r_clr;
                w_wdata  = 64'd0;
            end
            S_IDLE: begin
                w_mem.re = w_accept && (i_req_type == REQ_READ);
                w_raddr  = AW'(i_bucket_index);
            end
            S_FOLD1: begin
                // djb2: h*32 + h ; sdbm: h*64 + h*65536
                if (r_hash_kind == KIND_SDBM) begin
                    w_a = r_hash << 6;
                    w_b = r_hash << 16;
                end else begin
                    w_a = r_hash << 5;
                    w_b = r_hash;
                end
            end
            S_FOLD2: begin
                if (r_hash_kind == KIND_SDBM) begin
                    w_b  = r_hash;
                    w_op = '{sub: 1'b1, cin: 1'b1};
                end else begin
                    w_b = {24'd0, r_byte};
                end
            end
            S_FOLD3: w_b = {24'd0, r_byte};
            S_DIV: begin
                w_a  = {20'd0, w_trial};
                w_b  = {21'd0, w_mod};
                w_op = '{sub: 1'b1, cin: 1'b1};
            end
            S_MREAD: w_mem.re = 1'b1;
            S_INC_LO: begin
                w_a  = w_rdata[31:0];
                w_op = '{sub: 1'b0, cin: 1'b1};
            end
            S_INC_HI: begin
                w_a      = w_rdata[63:32];
                w_op     = '{sub: 1'b0, cin: r_carry};
                w_mem.we = 1'b1;
            end
            default: begin
                w_a = r_acc;
            end
        endcase
    end

    shb_alu u_alu (
        .i_a    (w_a),
        .i_b    (w_b),
        .i_op   (w_op),
        .o_sum  (w_sum),
        .o_cout (w_cout)
    );

    shb_hit_mem #(
        .DEPTH (NUM_BUCKETS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (w_mem),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_hash_kind    <= KIND_DJB2;
            r_bucket_count <= 11'd0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (w_cfg_wr && (paddr[2] == REG_HASH_KIND)) r_hash_kind <= pwdata[1:0];
            if (w_cfg_wr && (paddr[2] == REG_BUCKET_COUNT)) r_bucket_count <= pwdata[10:0];
            if (w_load_out) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // running hash: reset, kind writes and the finish state reload the seed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= DJB2_SEED;
        end else if (w_cfg_wr && (paddr[2] == REG_HASH_KIND)) begin
            r_hash <= (pwdata[1:0] == KIND_DJB2) ? DJB2_SEED : 32'd0;
        end else begin
            case (r_state)
                S_FOLD2: if (r_hash_kind != KIND_SDBM) r_hash <= w_sum;
                S_FOLD3: r_hash <= w_sum;
                S_FINISH: r_hash <= w_seed;
                default: r_hash <= r_hash;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_byte  <= i_data_byte;
                r_last  <= i_last_byte;
                r_rd_ok <= {22'd0, i_bucket_index} < 32'(NUM_BUCKETS);
            end
            S_FOLD1: r_acc <= w_sum;
            S_FOLD2: r_acc <= w_sum;
            S_FINISH: begin
                r_res_kind <= RES_HASH;
                r_div      <= r_hash;
                r_rem      <= 11'd0;
                r_cnt      <= '0;
                if (!w_kind_ok) r_res_hash <= '1;
                else r_res_hash <= r_hash;
            end
            S_DIV: begin
                // keep the difference when the trial value is not below the modulus
                r_rem <= w_cout ? w_sum[10:0] : w_trial[10:0];
                r_div <= r_div << 1;
                r_cnt <= r_cnt + 1'b1;
            end
            S_INC_LO: begin
                r_acc   <= w_sum;
                r_carry <= w_cout;
            end
            S_INC_HI: r_res_hash <= {21'd0, r_rem};
            S_RDWAIT: r_res_kind <= RES_HIT;
            default: r_acc <= r_acc;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_kind <= r_res_kind;
            if (r_res_kind == RES_HIT) begin
                r_out_hash <= 32'd0;
                r_out_hit  <= r_rd_ok ? w_rdata : 64'd0;
            end else begin
                r_out_hash <= r_res_hash;
                r_out_hit  <= 64'd0;
            end
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_hash_value  = r_out_hash;
    assign o_hit_count   = r_out_hit;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_IMP(a_rem_below_mod, i_clk, i_rst_n,
        (r_state == S_DIV) || (r_state == S_MREAD) || (r_state == S_INC_LO)
            || (r_state == S_INC_HI),
        r_rem < w_mod)
    `ASSERT_IMP(a_write_states, i_clk, i_rst_n,
        w_mem.we, (r_state == S_CLEAR) || (r_state == S_INC_HI))
    `ASSERT_IMP(a_inc_order, i_clk, i_rst_n,
        r_state == S_INC_HI, $past(r_state) == S_INC_LO)
    `ASSERT_NEXT(a_out_pending_kept, i_clk, i_rst_n,
        r_out_valid && !i_out_ready, r_out_valid && $stable(r_out_hash))

endmodule
`default_nettype wire
